@@ hw/rtl/typed_refcount_slot_allocator_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
`ifndef TYPED_REFCOUNT_SLOT_ALLOCATOR_ASSERT_SVH
`define TYPED_REFCOUNT_SLOT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRSA_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("slot allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRSA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slot allocator check failed");

`endif

@@ hw/rtl/trsa_pkg.sv @@
package trsa_pkg;

   localparam int NUM_WORDS_DEF = 64;

   typedef enum logic [1:0] {
      FUNC_GET     = 2'd0,
      FUNC_ACQUIRE = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   localparam logic [1:0] KIND_UNTYPED = 2'd0;
   localparam logic [1:0] KIND_WORD    = 2'd1;
   localparam logic [1:0] KIND_LONG    = 2'd2;

endpackage

@@ hw/rtl/typed_refcount_slot_allocator.sv @@
// Get: the scan state reads candidate slots and checks each read; a hit goes through the
// grant state (and grant2 for a long) to finish, a scan past the arena reports full.
// Acquire and release pass lookup and update, or go straight to finish outside the arena;
// clear zeroes every count. The slot memories share one read address. A new word is
// accepted in the cycle after the result word is loaded; a pending result may still wait.
// After reset a sweep untypes and zeroes every slot; no word is accepted until it ends.
`include "typed_refcount_slot_allocator_assert.svh"

module typed_refcount_slot_allocator #(
   parameter int NUM_WORDS = trsa_pkg::NUM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_base_offset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_slot_kind,
   input  logic [15:0] req_frame_offset,
   input  logic        req_frame_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_granted_offset,
   output logic        rsp_full_res,
   output logic        rsp_underflow,
   output logic [15:0] rsp_frame_end
);
   import trsa_pkg::*;

   localparam int AW = $clog2(NUM_WORDS);
   localparam logic [AW+1:0] WORDS_W = (AW+2)'(NUM_WORDS);
   localparam logic [AW-1:0] LAST_W = AW'(NUM_WORDS - 1);
   localparam logic [13:0] WORDS_IDX = 14'(NUM_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_LOOKUP,
      ST_UPDATE,
      ST_GRANT,
      ST_GRANT2,
      ST_FINISH
   } state_type;

   logic [1:0]  type_mem [NUM_WORDS];
   logic [7:0]  refs_mem [NUM_WORDS];

   state_type   state_ff, state_in;
   logic [11:0] base_ff, base_in;
   logic [15:0] high_mark_ff, high_mark_in;
   logic [1:0]  kind_ff, kind_in;
   logic        release_ff, release_in;
   logic        sweep_types_ff, sweep_types_in;
   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [AW:0] probe_ff, probe_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic        chk_valid_ff, chk_valid_in;
   logic [AW-1:0] op_addr_ff, op_addr_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [15:0] res_granted_ff, res_granted_in;
   logic        res_full_ff, res_full_in;
   logic        res_under_ff, res_under_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_granted_ff, rsp_granted_in;
   logic        rsp_full_ff, rsp_full_in;
   logic        rsp_under_ff, rsp_under_in;
   logic [15:0] rsp_end_ff, rsp_end_in;
   logic [1:0]  type_rd_ff;
   logic [7:0]  refs_rd_ff;

   logic [AW-1:0] rd_addr;
   logic          type_we, refs_we;
   logic [AW-1:0] type_wa, refs_wa;
   logic [1:0]    type_wd;
   logic [7:0]    refs_wd;

   logic [1:0]    req_kind;
   logic [15:0]   base_ext;
   logic [15:0]   off_diff;
   logic [13:0]   off_idx;
   logic          op_hit;
   logic          is_long;
   logic [AW+1:0] need;
   logic          probe_in_range;
   logic          chk_hit;
   logic [15:0]   grant_off;
   logic [15:0]   grant_end;
   logic [15:0]   frame_end_now;

   assign req_kind = (req_slot_kind == KIND_UNTYPED) ? KIND_WORD : req_slot_kind;
   assign base_ext = {4'd0, base_ff};
   assign off_diff = req_frame_offset - base_ext;
   assign off_idx = off_diff[15:2];
   assign op_hit = req_frame_mode && (req_frame_offset >= base_ext) && (off_idx < WORDS_IDX);
   assign is_long = (kind_ff == KIND_LONG);
   assign need = is_long ? (AW+2)'(2) : (AW+2)'(1);
   assign probe_in_range = ({1'b0, probe_ff} + need) <= WORDS_W;
   assign chk_hit = chk_valid_ff && (refs_rd_ff == 8'd0)
                    && ((type_rd_ff == kind_ff) || (type_rd_ff == KIND_UNTYPED));
   assign grant_off = base_ext + 16'({slot_ff, 2'b00});
   assign grant_end = grant_off + (is_long ? 16'd8 : 16'd4);
   assign frame_end_now = (high_mark_ff > base_ext) ? high_mark_ff : base_ext;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_offset = rsp_granted_ff;
   assign rsp_full_res = rsp_full_ff;
   assign rsp_underflow = rsp_under_ff;
   assign rsp_frame_end = rsp_end_ff;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      high_mark_in = high_mark_ff;
      kind_in = kind_ff;
      release_in = release_ff;
      sweep_types_in = sweep_types_ff;
      sweep_cnt_in = sweep_cnt_ff;
      probe_in = probe_ff;
      chk_addr_in = chk_addr_ff;
      chk_valid_in = chk_valid_ff;
      op_addr_in = op_addr_ff;
      slot_in = slot_ff;
      res_granted_in = res_granted_ff;
      res_full_in = res_full_ff;
      res_under_in = res_under_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_full_in = rsp_full_ff;
      rsp_under_in = rsp_under_ff;
      rsp_end_in = rsp_end_ff;
      rd_addr = probe_ff[AW-1:0];
      type_we = 1'b0;
      type_wa = sweep_cnt_ff;
      type_wd = KIND_UNTYPED;
      refs_we = 1'b0;
      refs_wa = sweep_cnt_ff;
      refs_wd = 8'd0;

      if (csr_valid) begin
         base_in = csr_base_offset;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               release_in = (func_type'(req_func) == FUNC_RELEASE);
               res_granted_in = 16'd0;
               res_full_in = 1'b0;
               res_under_in = 1'b0;
               op_addr_in = off_idx[AW-1:0];
               case (func_type'(req_func))
                  FUNC_GET: begin
                     probe_in = (req_kind == KIND_LONG) ? (AW+1)'(base_ff[2]) : '0;
                     chk_valid_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  FUNC_ACQUIRE, FUNC_RELEASE: begin
                     state_in = op_hit ? ST_LOOKUP : ST_FINISH;
                  end
                  FUNC_CLEAR: begin
                     sweep_cnt_in = '0;
                     sweep_types_in = 1'b0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            type_we = sweep_types_ff;
            refs_we = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == LAST_W) begin
               state_in = sweep_types_ff ? ST_IDLE : ST_FINISH;
            end
         end
         ST_SCAN: begin
            chk_addr_in = probe_ff[AW-1:0];
            chk_valid_in = probe_in_range;
            if (probe_in_range) begin
               probe_in = probe_ff + (is_long ? (AW+1)'(2) : (AW+1)'(1));
            end
            if (chk_hit) begin
               slot_in = chk_addr_ff;
               state_in = ST_GRANT;
            end else if (!chk_valid_ff && !probe_in_range) begin
               res_full_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_LOOKUP: begin
            rd_addr = op_addr_ff;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            refs_wa = op_addr_ff;
            if (release_ff) begin
               if (refs_rd_ff == 8'd0) begin
                  res_under_in = 1'b1;
               end else begin
                  refs_we = 1'b1;
                  refs_wd = refs_rd_ff - 8'd1;
               end
            end else if (refs_rd_ff != 8'hFF) begin
               refs_we = 1'b1;
               refs_wd = refs_rd_ff + 8'd1;
            end
            state_in = ST_FINISH;
         end
         ST_GRANT: begin
            type_we = 1'b1;
            type_wa = slot_ff;
            type_wd = kind_ff;
            refs_we = 1'b1;
            refs_wa = slot_ff;
            refs_wd = 8'd1;
            res_granted_in = grant_off;
            if (grant_end > high_mark_ff) begin
               high_mark_in = grant_end;
            end
            state_in = is_long ? ST_GRANT2 : ST_FINISH;
         end
         ST_GRANT2: begin
            type_we = 1'b1;
            type_wa = slot_ff + 1'b1;
            type_wd = KIND_LONG;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_full_in = res_full_ff;
               rsp_under_in = res_under_ff;
               rsp_end_in = frame_end_now;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         base_ff <= 12'd0;
         high_mark_ff <= 16'd0;
         sweep_types_ff <= 1'b1;
         sweep_cnt_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         high_mark_ff <= high_mark_in;
         sweep_types_ff <= sweep_types_in;
         sweep_cnt_ff <= sweep_cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      release_ff <= release_in;
      probe_ff <= probe_in;
      chk_addr_ff <= chk_addr_in;
      op_addr_ff <= op_addr_in;
      slot_ff <= slot_in;
      res_granted_ff <= res_granted_in;
      res_full_ff <= res_full_in;
      res_under_ff <= res_under_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_full_ff <= rsp_full_in;
      rsp_under_ff <= rsp_under_in;
      rsp_end_ff <= rsp_end_in;
   end

   always_ff @(posedge clock) begin
      if (type_we) begin
         type_mem[type_wa] <= type_wd;
      end
      type_rd_ff <= type_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem[refs_wa] <= refs_wd;
      end
      refs_rd_ff <= refs_mem[rd_addr];
   end

   `TRSA_ASSERT_SAME(a_busy_after_reset, clock, reset, $past(reset), !req_ready)
   `TRSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `TRSA_ASSERT_SAME(a_full_has_no_grant, clock, reset, rsp_valid && rsp_full_res,
      (rsp_granted_offset == 16'd0) && !rsp_underflow)
   `TRSA_ASSERT_NEXT(a_hit_grants, clock, reset, (state_ff == ST_SCAN) && chk_hit,
      (state_ff == ST_GRANT) && (slot_ff == $past(chk_addr_ff)))

endmodule

@@ tb/typed_refcount_slot_allocator_checker.sv @@
module typed_refcount_slot_allocator_checker
   import trsa_pkg::*;
#(
   parameter int NUM_WORDS = NUM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [11:0] csr_base_offset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_slot_kind,
   input  logic [15:0] req_frame_offset,
   input  logic        req_frame_mode,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_granted_offset,
   input  logic        rsp_full_res,
   input  logic        rsp_underflow,
   input  logic [15:0] rsp_frame_end,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] granted;
      logic        full;
      logic        under;
      logic [15:0] frame_end;
   } slot_result_t;

   logic [1:0]   kind_of [NUM_WORDS];
   logic [7:0]   count_of [NUM_WORDS];
   logic [15:0]  high_water;
   logic [11:0]  base_now;
   slot_result_t results_due [$];
   int           errors = 0;

   // Word index of an arena slot, or -1 for an offset below the base or past the arena.
   function automatic int slot_index(input logic [15:0] offset);
      int rel;
      rel = int'(offset) - int'(base_now);
      if (rel < 0 || (rel >> 2) >= NUM_WORDS)
         return -1;
      return rel >> 2;
   endfunction

   task automatic apply_slot_op(input logic [1:0] op, input logic [1:0] kind_in,
                                input logic [15:0] offset, input logic mode,
                                output slot_result_t r);
      logic [1:0]  kind;
      logic [15:0] cell_end;
      int          first;
      int          stride;
      int          hit;
      int          idx;
      r = '0;
      case (op)
         FUNC_GET: begin
            kind = (kind_in == KIND_UNTYPED) ? KIND_WORD : kind_in;
            first = (kind == KIND_LONG) ? int'(base_now[2]) : 0;
            stride = (kind == KIND_LONG) ? 2 : 1;
            hit = -1;
            for (int w = first; w + stride <= NUM_WORDS; w += stride) begin
               if (hit < 0 && count_of[w] == 8'd0 &&
                   (kind_of[w] == kind || kind_of[w] == KIND_UNTYPED))
                  hit = w;
            end
            if (hit >= 0) begin
               kind_of[hit] = kind;
               if (kind == KIND_LONG)
                  kind_of[hit + 1] = kind;
               count_of[hit] = 8'd1;
               r.granted = 16'(int'(base_now) + 4 * hit);
               cell_end = 16'(int'(base_now) + 4 * hit + ((kind == KIND_LONG) ? 8 : 4));
               if (cell_end > high_water)
                  high_water = cell_end;
            end else begin
               r.full = 1'b1;
            end
         end
         FUNC_ACQUIRE: begin
            idx = slot_index(offset);
            if (mode && idx >= 0) begin
               if (count_of[idx] != 8'hFF)
                  count_of[idx] = count_of[idx] + 8'd1;
            end
         end
         FUNC_RELEASE: begin
            idx = slot_index(offset);
            if (mode && idx >= 0) begin
               if (count_of[idx] == 8'd0)
                  r.under = 1'b1;
               else
                  count_of[idx] = count_of[idx] - 8'd1;
            end
         end
         default: begin
            foreach (count_of[i])
               count_of[i] = 8'd0;
         end
      endcase
      r.frame_end = (high_water > {4'd0, base_now}) ? high_water : {4'd0, base_now};
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result(input slot_result_t got);
      slot_result_t want;
      if (results_due.size() == 0) begin
         $display("%0t: result word with none expected, granted_offset %0d frame_end %0d",
                  $time, got.granted, got.frame_end);
         errors++;
      end else begin
         want = results_due.pop_front();
         compare_field("granted_offset", want.granted, got.granted);
         compare_field("full_res", 16'(want.full), 16'(got.full));
         compare_field("underflow", 16'(want.under), 16'(got.under));
         compare_field("frame_end", want.frame_end, got.frame_end);
      end
   endtask

   always @(posedge clock) begin
      slot_result_t r;
      if (reset) begin
         foreach (kind_of[i]) begin
            kind_of[i] = KIND_UNTYPED;
            count_of[i] = 8'd0;
         end
         high_water = 16'd0;
         base_now = 12'd0;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            base_now = csr_base_offset;
         if (req_valid && req_ready) begin
            apply_slot_op(req_func, req_slot_kind, req_frame_offset, req_frame_mode, r);
            results_due.push_back(r);
         end
         if (rsp_valid && rsp_ready)
            check_result({rsp_granted_offset, rsp_full_res, rsp_underflow, rsp_frame_end});
      end
      pending <= results_due.size();
      fail_count <= errors;
   end

endmodule

@@ tb/tb_typed_refcount_slot_allocator.sv @@
module tb_typed_refcount_slot_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import trsa_pkg::*;

   localparam int         NUM_WORDS = NUM_WORDS_DEF;
   localparam logic [1:0] KIND_POINTER = 2'd3;
   localparam int         SETTLE_CYCLES = NUM_WORDS + 16;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         PHASE_ITEMS = 50;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_base_offset = 12'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_GET;
   logic [1:0]  req_slot_kind = KIND_WORD;
   logic [15:0] req_frame_offset = 16'd0;
   logic        req_frame_mode = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_granted_offset;
   logic        rsp_full_res;
   logic        rsp_underflow;
   logic [15:0] rsp_frame_end;

   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          ready_hold = 0;
   int          ready_mode = 0;
   logic [7:0]  ready_phase = 8'd0;
   logic [11:0] current_base = 12'd0;

   typed_refcount_slot_allocator #(
      .NUM_WORDS(NUM_WORDS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_base_offset(csr_base_offset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_slot_kind(req_slot_kind),
      .req_frame_offset(req_frame_offset),
      .req_frame_mode(req_frame_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_granted_offset(rsp_granted_offset),
      .rsp_full_res(rsp_full_res),
      .rsp_underflow(rsp_underflow),
      .rsp_frame_end(rsp_frame_end)
   );

   typed_refcount_slot_allocator_checker #(
      .NUM_WORDS(NUM_WORDS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_base_offset(csr_base_offset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_slot_kind(req_slot_kind),
      .req_frame_offset(req_frame_offset),
      .req_frame_mode(req_frame_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_granted_offset(rsp_granted_offset),
      .rsp_full_res(rsp_full_res),
      .rsp_underflow(rsp_underflow),
      .rsp_frame_end(rsp_frame_end),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver switches among always ready, coin-flip, mostly stalled and periodic.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_hold <= $urandom_range(32, 200);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      ready_phase <= ready_phase + 8'd1;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (ready_phase[2:0] != 3'd0);
      endcase
   end

   task automatic send_item(input func_type op, input logic [1:0] kind,
                            input logic [15:0] offset, input logic mode);
      req_func <= op;
      req_slot_kind <= kind;
      req_frame_offset <= offset;
      req_frame_mode <= mode;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic write_base(input logic [11:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_base_offset <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      current_base = value;
   endtask

   function automatic logic [15:0] pick_offset();
      int sel;
      int b;
      sel = $urandom_range(0, 9);
      b = int'(current_base);
      if (sel == 0)
         return 16'($urandom);
      if (sel == 1 && b > 0)
         return 16'($urandom_range(0, b - 1));
      if (sel == 2)
         return 16'(b + 4 * NUM_WORDS + $urandom_range(0, 64));
      return 16'(b + 4 * $urandom_range(0, NUM_WORDS - 1) +
                 (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0));
   endfunction

   task automatic random_item(input int p_get, input int p_acq, input int p_rel);
      int          r;
      func_type    op;
      logic [1:0]  kind;
      r = $urandom_range(0, 99);
      if (r < p_get)
         op = FUNC_GET;
      else if (r < p_get + p_acq)
         op = FUNC_ACQUIRE;
      else if (r < p_get + p_acq + p_rel)
         op = FUNC_RELEASE;
      else
         op = FUNC_CLEAR;
      kind = ($urandom_range(0, 9) == 0) ? KIND_UNTYPED : 2'($urandom_range(1, 3));
      send_item(op, kind, pick_offset(), ($urandom_range(0, 9) != 0));
   endtask

   initial begin
      logic [11:0] base_plan [6];
      logic [11:0] next_base;
      int          target;
      base_plan = '{12'd4, 12'd0, 12'd4092, 12'd2, 12'd4095, 12'd1};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(FUNC_GET, KIND_WORD, 16'd0, 1'b1);
      send_item(FUNC_GET, KIND_UNTYPED, 16'd0, 1'b0);
      send_item(FUNC_GET, KIND_LONG, 16'd0, 1'b1);
      send_item(FUNC_GET, KIND_POINTER, 16'd0, 1'b1);
      send_item(FUNC_ACQUIRE, KIND_WORD, 16'd0, 1'b1);
      send_item(FUNC_ACQUIRE, KIND_WORD, 16'd0, 1'b0);
      send_item(FUNC_RELEASE, KIND_WORD, 16'd4, 1'b1);
      send_item(FUNC_RELEASE, KIND_WORD, 16'd4, 1'b1);
      send_item(FUNC_RELEASE, KIND_POINTER, 16'hFFFF, 1'b1);
      send_item(FUNC_ACQUIRE, KIND_POINTER, 16'hFFFF, 1'b0);
      send_item(FUNC_RELEASE, KIND_WORD, 16'd3, 1'b1);
      send_item(FUNC_CLEAR, KIND_WORD, 16'd0, 1'b1);
      send_item(FUNC_GET, KIND_WORD, 16'd0, 1'b1);
      send_item(FUNC_RELEASE, KIND_LONG, 16'd12, 1'b1);

      write_base(12'hFFF);
      send_item(FUNC_ACQUIRE, KIND_WORD, 16'd4094, 1'b1);
      send_item(FUNC_RELEASE, KIND_WORD, 16'd4094, 1'b1);
      send_item(FUNC_GET, KIND_LONG, 16'd0, 1'b1);
      send_item(FUNC_GET, KIND_POINTER, 16'd0, 1'b1);
      send_item(FUNC_ACQUIRE, KIND_WORD, 16'(4095 + 4 * (NUM_WORDS - 1)), 1'b1);
      send_item(FUNC_RELEASE, KIND_WORD, 16'(4095 + 4 * NUM_WORDS), 1'b1);

      for (int p = 0; p < 8; p++) begin
         next_base = (p < 6) ? base_plan[p] : 12'($urandom);
         write_base(next_base);
         if (p == 2) begin
            // Drive one slot's count past saturation, then walk it back down.
            target = int'(current_base) + 4 * $urandom_range(0, NUM_WORDS - 1);
            for (int i = 0; i < 270; i++)
               send_item(FUNC_ACQUIRE, 2'($urandom), 16'(target), 1'b1);
            for (int i = 0; i < 3; i++)
               send_item(FUNC_RELEASE, 2'($urandom), 16'(target), 1'b1);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case (p % 3)
               0: random_item(40, 25, 30);
               1: random_item(75, 8, 14);
               default: random_item(20, 25, 52);
            endcase
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/trsa_pkg.sv
hw/rtl/typed_refcount_slot_allocator.sv
tb/typed_refcount_slot_allocator_checker.sv
tb/tb_typed_refcount_slot_allocator.sv
